// File: hw/rtl/poq_pkg.sv
package poq_pkg;

  // List geometry.
  localparam int unsigned Depth = 64;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned OutCntW = 7;
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;

  // Operation codes carried in the func field.
  localparam logic [2:0] FuncPush      = 3'd0;
  localparam logic [2:0] FuncPop       = 3'd1;
  localparam logic [2:0] FuncInsert    = 3'd2;
  localparam logic [2:0] FuncRemoveAt  = 3'd3;
  localparam logic [2:0] FuncRemoveAll = 3'd4;

  // Status codes returned with each result.
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;
  localparam logic [1:0] StatusRange = 2'd3;

  // Request item.
  typedef struct packed {
    logic [2:0]              func;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } poq_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [WordW-1:0] read_value;
    logic [OutCntW-1:0]      removed_count;
    logic [OutCntW-1:0]      entry_count;
  } poq_out_t;

  // What every cell of the chain does in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_e;

  // Control broadcast to all cells.
  typedef struct packed {
    cell_op_e         op;
    logic [CntW-1:0]  len;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] value;
    logic [WordW-1:0] head;
    logic             keep;
  } poq_cell_ctrl_t;

endpackage

// File: hw/rtl/poq_cell.sv
module poq_cell
  import poq_pkg::*;
(
  input  logic               clk_i,
  input  logic [CntW-1:0]    idx_i,
  input  poq_cell_ctrl_t     ctrl_i,
  input  logic [WordW-1:0]   prev_i,
  input  logic [WordW-1:0]   next_i,
  output logic [WordW-1:0]   word_o
);

  logic [WordW-1:0] word_d, word_q;
  logic [CntW-1:0]  tail_idx;

  // Last occupied place of the list while it is being rotated.
  assign tail_idx = CntW'(ctrl_i.len - CntW'(1));

  // Each cell either keeps its word or takes one from a neighbour or the broadcast.
  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
        word_d = word_q;
      end
      CELL_PUSH: begin
        if (idx_i == ctrl_i.len) begin
          word_d = ctrl_i.value;
        end
      end
      CELL_POP: begin
        word_d = next_i;
      end
      CELL_INSERT: begin
        if (CmpW'(idx_i) > CmpW'(ctrl_i.pos)) begin
          word_d = prev_i;
        end else if (CmpW'(idx_i) == CmpW'(ctrl_i.pos)) begin
          word_d = ctrl_i.value;
        end
      end
      CELL_ROTATE: begin
        if (ctrl_i.keep && (idx_i == tail_idx)) begin
          word_d = ctrl_i.head;
        end else begin
          word_d = next_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  // The stored word needs no reset: places beyond the count are never read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: hw/rtl/positional_ordered_queue.sv
// Ordered list of up to Depth signed words, head first, held in a row of cells.
// Requests arrive on in_valid_i/in_ready_o with in_data_i (func, value,
// position); each request gives exactly one result on out_valid_o/out_ready_i
// with out_data_o (status, read_value, removed_count, entry_count).
// Push, pop and insert act on all cells at once: the result is written to the
// output register from the execute state, and the block then returns to idle
// for the next request, so it takes none while one is running.
// Remove at a valid position and remove all equal on a non-empty list rotate
// the list once through the chain, one entry per cycle, dropping the selected
// entries on the way; the result is written from the finish state once the
// rotation ends, and the block then returns to idle for the next request.
// The result sits in an output register; a request can be accepted while it
// waits. If the receiver stalls, a finished request waits for the register to
// free before it writes its result and the block takes nothing further.
// Reset empties the list and drops any pending result; the stored words are
// not cleared, as only places below the count are ever read.
module positional_ordered_queue
  import poq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  poq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output poq_out_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_d, state_q;
  logic [CntW-1:0]  count_d, count_q;
  logic [CntW-1:0]  step_d, step_q;
  logic [CntW-1:0]  orig_d, orig_q;
  logic [CntW-1:0]  rm_d, rm_q;
  logic [WordW-1:0] rd_d, rd_q;
  poq_in_t          cmd_d, cmd_q;
  poq_out_t         out_d, out_q;
  logic             out_valid_d, out_valid_q;

  logic [WordW-1:0] words [Depth];
  poq_cell_ctrl_t   cell_ctrl;

  logic             slot_free;
  logic             is_full, is_empty, is_rm_at, drop, last_step;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  logic             go_rot;
  cell_op_e         imm_op;
  poq_out_t         imm_res;
  logic [CntW-1:0]  imm_count;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign is_full  = (count_q == CntW'(Depth));
  assign is_empty = (count_q == '0);
  assign pos_ext  = CmpW'(cmd_q.position);
  assign cnt_ext  = CmpW'(count_q);
  assign is_rm_at = (cmd_q.func == FuncRemoveAt);
  assign last_step = (step_q == CntW'(orig_q - CntW'(1)));

  // During a rotation the head entry is dropped if it is the one selected.
  assign drop = is_rm_at ? (CmpW'(step_q) == pos_ext) : (words[0] == cmd_q.value);

  // Decode the held request into an immediate action on all cells or a rotation.
  always_comb begin
    go_rot    = 1'b0;
    imm_op    = CELL_HOLD;
    imm_count = count_q;
    imm_res   = '{status: StatusOk, read_value: '0, removed_count: '0,
                  entry_count: OutCntW'(count_q)};
    unique case (cmd_q.func)
      FuncPush: begin
        if (is_full) begin
          imm_res.status = StatusFull;
        end else begin
          imm_op    = CELL_PUSH;
          imm_count = CntW'(count_q + CntW'(1));
        end
      end
      FuncPop: begin
        if (is_empty) begin
          imm_res.status = StatusEmpty;
        end else begin
          imm_op                = CELL_POP;
          imm_count             = CntW'(count_q - CntW'(1));
          imm_res.read_value    = words[0];
          imm_res.removed_count = OutCntW'(1);
        end
      end
      FuncInsert: begin
        if (is_full) begin
          imm_res.status = StatusFull;
        end else if (pos_ext > cnt_ext) begin
          imm_res.status = StatusRange;
        end else begin
          imm_op    = CELL_INSERT;
          imm_count = CntW'(count_q + CntW'(1));
        end
      end
      FuncRemoveAt: begin
        if (is_empty) begin
          imm_res.status = StatusEmpty;
        end else if (pos_ext >= cnt_ext) begin
          imm_res.status = StatusRange;
        end else begin
          go_rot = 1'b1;
        end
      end
      FuncRemoveAll: begin
        go_rot = !is_empty;
      end
      default: begin
        go_rot = 1'b0;
      end
    endcase
    imm_res.entry_count = OutCntW'(imm_count);
  end

  // Control broadcast to the cell row.
  always_comb begin
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.len   = count_q;
    cell_ctrl.pos   = cmd_q.position;
    cell_ctrl.value = cmd_q.value;
    cell_ctrl.head  = words[0];
    cell_ctrl.keep  = !drop;
    if ((state_q == S_EXEC) && !go_rot && slot_free) begin
      cell_ctrl.op = imm_op;
    end else if (state_q == S_ROT) begin
      cell_ctrl.op = CELL_ROTATE;
    end
  end

  // Row of cells, each linked to both neighbours.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [WordW-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = words[0];
    end else begin : g_inner_prev
      assign prev_w = words[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_w = words[i];
    end else begin : g_inner_next
      assign next_w = words[i+1];
    end
    poq_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (CntW'(i)),
      .ctrl_i (cell_ctrl),
      .prev_i (prev_w),
      .next_i (next_w),
      .word_o (words[i])
    );
  end

  // Sequencer: take a request, run it, write the result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    orig_d      = orig_q;
    rm_d        = rm_q;
    rd_d        = rd_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go_rot) begin
          step_d  = '0;
          orig_d  = count_q;
          rm_d    = '0;
          rd_d    = '0;
          state_d = S_ROT;
        end else if (slot_free) begin
          out_d       = imm_res;
          out_valid_d = 1'b1;
          count_d     = imm_count;
          state_d     = S_IDLE;
        end
      end
      S_ROT: begin
        step_d = CntW'(step_q + CntW'(1));
        if (drop) begin
          count_d = CntW'(count_q - CntW'(1));
          rm_d    = CntW'(rm_q + CntW'(1));
          if (is_rm_at) begin
            rd_d = words[0];
          end
        end
        if (last_step) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_d = '{status: StatusOk, read_value: rd_q,
                    removed_count: OutCntW'(rm_q), entry_count: OutCntW'(count_q)};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      orig_q      <= '0;
      rm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      orig_q      <= orig_d;
      rm_q        <= rm_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rd_q  <= rd_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The list never holds more than Depth entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds list depth");

  // A rotation never runs past the entries it started with.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (step_q < orig_q))
    else $error("rotation step beyond starting count");

  // Entries kept plus entries dropped always add up to the starting count.
  a_rot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> ((CntW + 1)'(count_q) + (CntW + 1)'(rm_q) ==
                            (CntW + 1)'(orig_q)))
    else $error("rotation lost or duplicated an entry");

  // A fresh result is only written as the sequencer returns to idle.
  a_result_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (state_q == S_IDLE))
    else $error("result written while a request is still running");

endmodule
